>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types, codes and constants of the LRU block buffer cache.
// ----------------------------------------------------------------------------
package lbc_pkg;

  // Default geometry
  localparam int SLOT_COUNT_DEF = 16;

  // Field widths
  localparam int OP_W   = 3;
  localparam int BLK_W  = 16;
  localparam int SIDX_W = 4;
  localparam int CMD_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_GET   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET = 3'd4;

  // Disk command codes
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [BLK_W-1:0]  block_number;
    logic [SIDX_W-1:0] slot_index;
  } lbc_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  disk_command;
    logic [BLK_W-1:0]  disk_block;
    logic [SIDX_W-1:0] command_slot;
    logic              was_hit;
    logic              last;
  } lbc_res_t;

  // Scan counter actions
  typedef enum logic [1:0] {
    SC_HOLD,
    SC_CLR,
    SC_STEP,
    SC_NEXT
  } scan_op_t;

  // Tag memory read address source
  typedef enum logic [1:0] {
    TA_IDX,
    TA_ORD,
    TA_SIDX
  } taddr_sel_t;

  // Selected slot register source
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_RD,
    SEL_ORD,
    SEL_FREE
  } sel_src_t;

  // Recency order memory write
  typedef enum logic [1:0] {
    OW_NONE,
    OW_SHIFT,
    OW_APPEND,
    OW_ALLOC
  } ord_wr_t;

  // Result to produce
  typedef enum logic [2:0] {
    EM_NONE,
    EM_EMPTY,
    EM_EVICT,
    EM_FINAL,
    EM_WRITE,
    EM_FLUSH
  } emit_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch;
    scan_op_t   scan;
    taddr_sel_t taddr;
    logic       track_free;
    sel_src_t   sel_src;
    logic       install;
    logic       inst_free;
    ord_wr_t    ord_wr;
    logic       used_inc;
    logic       clear_all;
    emit_t      emit;
  } lbc_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic rd_ok;
    logic match;
    logic scan_top;
    logic ord_match;
    logic used_top;
    logic full;
    logic pend_any;
    logic flush_last;
  } lbc_sts_t;

endpackage

>>> src/lbc_dpath.sv
// ----------------------------------------------------------------------------
// lbc_dpath
// Slot tag and recency order memories, slot marks, scan counter and result
// registers, driven one step per cycle by the controller.
// ----------------------------------------------------------------------------
module lbc_dpath #(
  parameter int SLOT_COUNT = lbc_pkg::SLOT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lbc_pkg::lbc_cmd_t command,
  input  lbc_pkg::lbc_ctl_t ctl,
  output lbc_pkg::lbc_sts_t sts,
  output logic             result_valid,
  output lbc_pkg::lbc_res_t result
);

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int CW    = $clog2(SLOT_COUNT + 1);
  localparam int SIDXW = lbc_pkg::SIDX_W;
  localparam int BLKW  = lbc_pkg::BLK_W;

  // Latched request
  lbc_pkg::lbc_cmd_t req;

  // Memories
  logic [BLKW-1:0] tag_mem [SLOT_COUNT];
  logic [SW-1:0]   ord_mem [SLOT_COUNT];
  logic [BLKW-1:0] tag_rd;
  logic [SW-1:0]   ord_rd;

  // Slot marks and fill count
  logic [SLOT_COUNT-1:0] valid;
  logic [SLOT_COUNT-1:0] dirty;
  logic [SLOT_COUNT-1:0] fresh;
  logic [CW-1:0]         used;

  // Scan state
  logic [CW-1:0] idx;
  logic [SW-1:0] rd_idx;
  logic          rd_ok;

  // Selection state
  logic [SW-1:0] sel;
  logic          hit;
  logic          free_found;
  logic [SW-1:0] free_slot;

  logic                  idx_ok;
  logic [SW-1:0]         taddr;
  logic                  taddr_ok;
  logic [SW-1:0]         inst;
  logic [SW-1:0]         sidx_slot;
  logic                  sidx_ok;
  logic                  wr_hit;
  logic                  fl_hit;
  logic [SLOT_COUNT-1:0] pend;
  logic [SLOT_COUNT-1:0] rd_mask;
  logic                  read_fresh;
  logic                  res_fire;
  lbc_pkg::lbc_res_t     res_next;

  assign idx_ok     = idx < CW'(SLOT_COUNT);
  assign sidx_ok    = int'(req.slot_index) < SLOT_COUNT;
  assign sidx_slot  = SW'(req.slot_index);
  assign inst       = ctl.inst_free ? free_slot : sel;
  assign pend       = valid & dirty;
  assign rd_mask    = SLOT_COUNT'(1) << rd_idx;
  assign wr_hit     = sidx_ok && valid[sidx_slot] && dirty[sidx_slot];
  assign fl_hit     = rd_ok && pend[rd_idx];
  assign read_fresh = (req.opcode == lbc_pkg::OP_READ) && fresh[sel];

  // Pick the tag read address
  always_comb begin
    case (ctl.taddr)
      lbc_pkg::TA_ORD: begin
        taddr    = ord_rd;
        taddr_ok = 1'b1;
      end
      lbc_pkg::TA_SIDX: begin
        taddr    = sidx_slot;
        taddr_ok = sidx_ok;
      end
      default: begin
        taddr    = idx[SW-1:0];
        taddr_ok = idx_ok;
      end
    endcase
  end

  // Report status to the controller
  always_comb begin
    sts.rd_ok      = rd_ok;
    sts.match      = rd_ok && valid[rd_idx] && (tag_rd == req.block_number);
    sts.scan_top   = rd_ok && (rd_idx == SW'(SLOT_COUNT - 1));
    sts.ord_match  = rd_ok && (ord_rd == sel);
    sts.used_top   = rd_ok && ((CW'(rd_idx) + CW'(1)) == used);
    sts.full       = used == CW'(SLOT_COUNT);
    sts.pend_any   = |pend;
    sts.flush_last = fl_hit && ((pend & ~rd_mask) == '0);
  end

  // Latch request, scan counter and selection registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      case (ctl.scan)
        lbc_pkg::SC_CLR: begin
          idx   <= '0;
          rd_ok <= 1'b0;
        end
        lbc_pkg::SC_STEP: begin
          if (idx_ok) begin
            idx    <= idx + CW'(1);
            rd_idx <= idx[SW-1:0];
            rd_ok  <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
          end
        end
        lbc_pkg::SC_NEXT: begin
          idx   <= CW'(rd_idx) + CW'(1);
          rd_ok <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      req        <= command;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      // track the lowest free slot while the tags go by
      if (ctl.track_free && rd_ok && !valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_idx;
      end
      case (ctl.sel_src)
        lbc_pkg::SEL_RD: begin
          sel <= rd_idx;
          hit <= 1'b1;
        end
        lbc_pkg::SEL_ORD:  sel <= ord_rd;
        lbc_pkg::SEL_FREE: sel <= free_slot;
        default: ;
      endcase
    end
  end

  // Tag memory
  always_ff @(posedge clk) begin
    if (ctl.install) begin
      tag_mem[inst] <= req.block_number;
    end
    if (taddr_ok) begin
      tag_rd <= tag_mem[taddr];
    end
  end

  // Recency order memory
  always_ff @(posedge clk) begin
    case (ctl.ord_wr)
      lbc_pkg::OW_SHIFT: begin
        if (rd_ok) begin
          ord_mem[rd_idx - SW'(1)] <= ord_rd;
        end
      end
      lbc_pkg::OW_APPEND: ord_mem[SW'(used - CW'(1))] <= sel;
      lbc_pkg::OW_ALLOC:  ord_mem[SW'(used)] <= free_slot;
      default: ;
    endcase
    if (idx_ok) begin
      ord_rd <= ord_mem[idx[SW-1:0]];
    end
  end

  // Slot marks and fill count
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      valid <= '0;
      dirty <= '0;
      fresh <= '0;
      used  <= '0;
    end else begin
      if (ctl.install) begin
        valid[inst] <= 1'b1;
        dirty[inst] <= 1'b1;
        fresh[inst] <= 1'b1;
      end
      if (ctl.used_inc) begin
        used <= used + CW'(1);
      end
      case (ctl.emit)
        lbc_pkg::EM_FINAL: begin
          if (read_fresh) begin
            fresh[sel] <= 1'b0;
            dirty[sel] <= 1'b0;
          end
        end
        lbc_pkg::EM_WRITE: begin
          if (wr_hit) begin
            dirty[sidx_slot] <= 1'b0;
          end
        end
        lbc_pkg::EM_FLUSH: begin
          if (fl_hit) begin
            dirty[rd_idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Form the next result
  always_comb begin
    res_fire = 1'b0;
    res_next = '0;
    case (ctl.emit)
      lbc_pkg::EM_EMPTY: begin
        res_fire      = 1'b1;
        res_next.last = 1'b1;
      end
      lbc_pkg::EM_EVICT: begin
        res_fire              = pend[sel];
        res_next.disk_command = lbc_pkg::CMD_WRITE;
        res_next.disk_block   = tag_rd;
        res_next.command_slot = SIDXW'(sel);
      end
      lbc_pkg::EM_FINAL: begin
        res_fire              = 1'b1;
        res_next.disk_command = read_fresh ? lbc_pkg::CMD_READ : lbc_pkg::CMD_NONE;
        res_next.disk_block   = req.block_number;
        res_next.command_slot = SIDXW'(sel);
        res_next.was_hit      = hit;
        res_next.last         = 1'b1;
      end
      lbc_pkg::EM_WRITE: begin
        res_fire              = 1'b1;
        res_next.command_slot = req.slot_index;
        res_next.last         = 1'b1;
        if (wr_hit) begin
          res_next.disk_command = lbc_pkg::CMD_WRITE;
          res_next.disk_block   = tag_rd;
        end
      end
      lbc_pkg::EM_FLUSH: begin
        res_fire              = fl_hit;
        res_next.disk_command = lbc_pkg::CMD_WRITE;
        res_next.disk_block   = tag_rd;
        res_next.command_slot = SIDXW'(rd_idx);
        res_next.last         = sts.flush_last;
      end
      default: ;
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      result <= res_next;
    end
  end

endmodule

>>> src/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// lbc_ctrl
// Operation sequencer: walks the tag search, recency reordering, eviction and
// flush steps, and issues one datapath command set per cycle.
// ----------------------------------------------------------------------------
module lbc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [lbc_pkg::OP_W-1:0] opcode,
  input  lbc_pkg::lbc_sts_t        sts,
  output lbc_pkg::lbc_ctl_t        ctl,
  output logic                     busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_POS,
    S_SHIFT,
    S_APPEND,
    S_EVICT_RD,
    S_EVICT_TAG,
    S_EVICT_WB,
    S_ALLOC,
    S_FINAL,
    S_WRITE_RD,
    S_WRITE,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  // Decode state and status into commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          ctl.latch = 1'b1;
          case (opcode)
            lbc_pkg::OP_GET, lbc_pkg::OP_READ: begin
              ctl.scan   = lbc_pkg::SC_CLR;
              state_next = S_SEARCH;
            end
            lbc_pkg::OP_WRITE: begin
              state_next = S_WRITE_RD;
            end
            lbc_pkg::OP_FLUSH: begin
              if (sts.pend_any) begin
                ctl.scan   = lbc_pkg::SC_CLR;
                state_next = S_FLUSH;
              end else begin
                ctl.emit = lbc_pkg::EM_EMPTY;
              end
            end
            lbc_pkg::OP_RESET: begin
              ctl.clear_all = 1'b1;
              ctl.emit      = lbc_pkg::EM_EMPTY;
            end
            default: begin
              ctl.emit = lbc_pkg::EM_EMPTY;
            end
          endcase
        end
      end
      // compare one tag per cycle, note the lowest free slot
      S_SEARCH: begin
        ctl.scan       = lbc_pkg::SC_STEP;
        ctl.taddr      = lbc_pkg::TA_IDX;
        ctl.track_free = 1'b1;
        if (sts.match) begin
          ctl.sel_src = lbc_pkg::SEL_RD;
          ctl.scan    = lbc_pkg::SC_CLR;
          state_next  = S_POS;
        end else if (sts.scan_top) begin
          if (sts.full) begin
            ctl.scan   = lbc_pkg::SC_CLR;
            state_next = S_EVICT_RD;
          end else begin
            state_next = S_ALLOC;
          end
        end
      end
      // find the hit slot in the recency order
      S_POS: begin
        ctl.scan = lbc_pkg::SC_STEP;
        if (sts.ord_match) begin
          if (sts.used_top) begin
            state_next = S_APPEND;
          end else begin
            ctl.scan   = lbc_pkg::SC_NEXT;
            state_next = S_SHIFT;
          end
        end
      end
      // close the gap one entry per cycle
      S_SHIFT: begin
        ctl.scan = lbc_pkg::SC_STEP;
        if (sts.rd_ok) begin
          ctl.ord_wr = lbc_pkg::OW_SHIFT;
        end
        if (sts.used_top) begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        ctl.ord_wr = lbc_pkg::OW_APPEND;
        state_next = S_FINAL;
      end
      S_EVICT_RD: begin
        ctl.scan   = lbc_pkg::SC_STEP;
        state_next = S_EVICT_TAG;
      end
      S_EVICT_TAG: begin
        ctl.sel_src = lbc_pkg::SEL_ORD;
        ctl.taddr   = lbc_pkg::TA_ORD;
        state_next  = S_EVICT_WB;
      end
      // write back the victim if dirty, retag it, then reorder
      S_EVICT_WB: begin
        ctl.emit    = lbc_pkg::EM_EVICT;
        ctl.install = 1'b1;
        ctl.scan    = lbc_pkg::SC_NEXT;
        state_next  = S_SHIFT;
      end
      S_ALLOC: begin
        ctl.install   = 1'b1;
        ctl.inst_free = 1'b1;
        ctl.ord_wr    = lbc_pkg::OW_ALLOC;
        ctl.used_inc  = 1'b1;
        ctl.sel_src   = lbc_pkg::SEL_FREE;
        state_next    = S_FINAL;
      end
      S_FINAL: begin
        ctl.emit   = lbc_pkg::EM_FINAL;
        state_next = S_IDLE;
      end
      S_WRITE_RD: begin
        ctl.taddr  = lbc_pkg::TA_SIDX;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        ctl.emit   = lbc_pkg::EM_WRITE;
        state_next = S_IDLE;
      end
      // write back dirty slots in slot order
      S_FLUSH: begin
        ctl.scan  = lbc_pkg::SC_STEP;
        ctl.taddr = lbc_pkg::TA_IDX;
        ctl.emit  = lbc_pkg::EM_FLUSH;
        if (sts.flush_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
    end
  end

endmodule

>>> src/lru_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit
// LRU write-back buffer cache controller: slot lookup, allocation, eviction,
// clean and flush, answered as a stream of disk commands.
// ----------------------------------------------------------------------------
// Raise start with a command while busy is low; the command is taken on that
// clock edge. Every result shows on result for exactly one cycle with
// result_valid high and cannot be held off; result.last marks the final one
// of a command. Reset and unused opcodes, and a flush with nothing dirty,
// answer in the next cycle and leave busy low. Write reads the slot's tag
// and then answers with one result. Get and read walk the tags one slot per
// cycle; a hit then walks the recency order one entry per cycle to move the
// slot to the most recent end, and a miss with no free slot reads the victim
// and shifts the whole order. Flush walks the slots one per cycle and ends
// with the last dirty one. Busy drops in the cycle the final result appears,
// so the next command may be taken right then.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_block_buffer_cache_unit #(
  parameter int SLOT_COUNT = lbc_pkg::SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lbc_pkg::lbc_cmd_t command,
  output logic              busy,
  output logic              result_valid,
  output lbc_pkg::lbc_res_t result
);

  lbc_pkg::lbc_ctl_t ctl;
  lbc_pkg::lbc_sts_t sts;

  // Sequencer
  lbc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (command.opcode),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  // Storage and result path
  lbc_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .ctl          (ctl),
    .sts          (sts),
    .result_valid (result_valid),
    .result       (result)
  );

  // Check sequencing against the result stream
  `ASSERT_SAME(a_mid_result_busy, clk, rst, result_valid && !result.last, busy, "non-final result while idle")
  `ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || result_valid, "accepted command left no trace")
  `ASSERT_SAME(a_disk_read_last, clk, rst, result_valid && (result.disk_command == lbc_pkg::CMD_READ), result.last, "disk read not final")
  `ASSERT_SAME(a_hit_no_write, clk, rst, result_valid && result.was_hit, result.disk_command != lbc_pkg::CMD_WRITE, "hit with disk write")

endmodule
